>>> rtl/core/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg: retransmit tracker table shared definitions
// Slot count, derived widths, operation and result codes, payload structs
// and the write bundle for the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

    // table geometry
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // at most this many retransmits per scan
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam int SEQ_W   = 31;
    localparam int TIME_W  = 32;
    localparam int INTV_W  = 16;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_SENT      = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_ACKED     = 3'd2,
        KIND_UNMATCHED = 3'd3,
        KIND_RETX      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        op_t              operation;
        logic [SEQ_W-1:0] ack_seq;
    } in_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [3:0]       slot;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } out_item_t;

    // write request into the slot store
    typedef struct packed {
        logic              seq_we;
        logic              stamp_we;
        logic [SLOT_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
    } rtt_wr_t;

    // slot index reduced to the 4-bit result field
    function automatic logic [3:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+3:0] wide;
        wide = {4'b0000, idx};
        return wide[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rtt_store.sv
// ----------------------------------------------------------------------------
// rtt_store: per-slot sequence number and timestamp memories
// One write port per memory, one shared read address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_store
    import rtt_pkg::*;
(
    input  wire logic              clk,
    input  wire rtt_wr_t           wr,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output logic [SEQ_W-1:0]       rd_seq,
    output logic [TIME_W-1:0]      rd_stamp
);

    logic [SEQ_W-1:0]  seq_mem   [SLOTS];
    logic [TIME_W-1:0] stamp_mem [SLOTS];
    logic [SEQ_W-1:0]  rd_seq_reg;
    logic [TIME_W-1:0] rd_stamp_reg;

    // sequence number memory
    always_ff @(posedge clk)
    begin
        if (wr.seq_we)
        begin
            seq_mem[wr.addr] <= wr.seq;
        end
        rd_seq_reg <= seq_mem[rd_addr];
    end

    // timestamp memory
    always_ff @(posedge clk)
    begin
        if (wr.stamp_we)
        begin
            stamp_mem[wr.addr] <= wr.stamp;
        end
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    assign rd_seq   = rd_seq_reg;
    assign rd_stamp = rd_stamp_reg;

endmodule

`default_nettype wire

>>> rtl/core/retransmit_tracker_table.sv
// Flow: a send result goes straight into the output register; an ack walks the
// 16-slot store one slot per cycle through its read port, holding on a slot while
// a result waits for room in the output register, and a tick does so when a scan
// is due. One item at a time; the next is taken in idle with room in the output.
// Reset: valid bits, time, sequence counter and tick counter clear, the scan
// interval returns to 2; slot memories are not cleared.
// ----------------------------------------------------------------------------
// retransmit_tracker_table: sender-side table of unacknowledged messages
// Assigns sequence numbers, tracks slots, matches acks and emits timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_tracker_table
    import rtt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_item,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_item,
    // scan interval write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [INTV_W-1:0] cfg_data
);

    // control state
    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               is_ack_reg, is_ack_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_v_reg, pend_v_next;
    logic               out_v_reg, out_v_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [SEQ_W-1:0]   nseq_reg, nseq_next;
    logic [INTV_W-1:0]  tss_reg, tss_next;
    logic [INTV_W-1:0]  intv_reg, intv_next;

    // payload
    logic [SEQ_W-1:0]   ack_seq_reg, ack_seq_next;
    out_item_t          pend_reg, pend_next;
    out_item_t          out_reg, out_next;

    // store interface
    rtt_wr_t            wr;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SEQ_W-1:0]   rd_seq;
    logic [TIME_W-1:0]  rd_stamp;

    // decode
    logic               out_free;
    logic               accept;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic [INTV_W-1:0]  tick_cnt;
    logic               scan_due;
    logic [TIME_W-1:0]  age;
    logic [INTV_W:0]    timeout;
    logic               cur_valid;
    logic               hit_ack;
    logic               hit_tick;
    logic               at_end;
    logic               adv;

    rtt_store u_store (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_seq   (rd_seq),
        .rd_stamp (rd_stamp)
    );

    // handshake
    assign out_free  = !out_v_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // tick bookkeeping
    assign tick_cnt = tss_reg + 1'b1;
    assign scan_due = !(tick_cnt < intv_reg);

    // per-slot evaluation on the registered read data
    assign timeout   = {intv_reg, 1'b0};
    assign age       = now_reg - rd_stamp;
    assign cur_valid = valid_reg[idx_reg];
    assign hit_ack   = cur_valid && (rd_seq == ack_seq_reg);
    assign hit_tick  = cur_valid && (age >= TIME_W'(timeout))
                       && (cnt_reg < CNT_W'(MAX_OUT));
    assign at_end    = (idx_reg == SLOT_W'(SLOTS - 1));

    // a scan step that emits waits for room in the output register
    always_comb
    begin
        adv = 1'b0;
        if (state_reg == ST_SCAN)
        begin
            if (is_ack_reg)
            begin
                adv = (hit_ack || at_end) ? out_free : 1'b1;
            end
            else
            begin
                adv = (hit_tick && pend_v_reg) ? out_free : 1'b1;
            end
        end
    end

    // read address: next slot on a step, same slot on a stall, slot 0 outside a scan
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_addr = adv ? (idx_reg + 1'b1) : idx_reg;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_item.operation == OP_ACK))
                begin
                    state_next = ST_SCAN;
                end
                else if (accept && (in_item.operation == OP_TICK) && scan_due)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    if (is_ack_reg && (hit_ack || at_end))
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_v_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        idx_next     = idx_reg;
        is_ack_next  = is_ack_reg;
        cnt_next     = cnt_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        out_v_next   = out_v_reg && out_stall;
        out_next     = out_reg;
        valid_next   = valid_reg;
        now_next     = now_reg;
        nseq_next    = nseq_reg;
        tss_next     = tss_reg;
        intv_next    = intv_reg;
        ack_seq_next = ack_seq_reg;
        wr           = '0;

        if (cfg_valid && cfg_ready)
        begin
            intv_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                cnt_next = '0;
                if (accept)
                begin
                    unique case (in_item.operation)
                        OP_SEND:
                        begin
                            nseq_next    = nseq_reg + 1'b1;
                            out_v_next   = 1'b1;
                            out_next.seq  = nseq_reg;
                            out_next.last = 1'b1;
                            if (free_found)
                            begin
                                out_next.kind        = KIND_SENT;
                                out_next.slot        = slot_field(free_idx);
                                valid_next[free_idx] = 1'b1;
                                wr.seq_we   = 1'b1;
                                wr.stamp_we = 1'b1;
                                wr.addr     = free_idx;
                                wr.seq      = nseq_reg;
                                wr.stamp    = now_reg;
                            end
                            else
                            begin
                                out_next.kind = KIND_FULL;
                                out_next.slot = '0;
                            end
                        end
                        OP_ACK:
                        begin
                            is_ack_next  = 1'b1;
                            ack_seq_next = in_item.ack_seq;
                        end
                        OP_TICK:
                        begin
                            is_ack_next = 1'b0;
                            pend_v_next = 1'b0;
                            now_next    = now_reg + 1'b1;
                            tss_next    = scan_due ? '0 : tick_cnt;
                        end
                        OP_NOP:
                        begin
                            is_ack_next = is_ack_reg;
                        end
                        default:
                        begin
                            is_ack_next = is_ack_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (is_ack_reg)
                    begin
                        // ack: first match frees its slot, else unmatched at the end
                        if (hit_ack)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            out_v_next = 1'b1;
                            out_next   = '{kind: KIND_ACKED, slot: slot_field(idx_reg),
                                           seq: ack_seq_reg, last: 1'b1};
                        end
                        else if (at_end)
                        begin
                            out_v_next = 1'b1;
                            out_next   = '{kind: KIND_UNMATCHED, slot: 4'd0,
                                           seq: ack_seq_reg, last: 1'b1};
                        end
                    end
                    else if (hit_tick)
                    begin
                        // timeout: older pending result moves out, this one waits
                        if (pend_v_reg)
                        begin
                            out_v_next = 1'b1;
                            out_next   = pend_reg;
                        end
                        pend_v_next = 1'b1;
                        pend_next   = '{kind: KIND_RETX, slot: slot_field(idx_reg),
                                        seq: rd_seq, last: 1'b0};
                        cnt_next    = cnt_reg + 1'b1;
                        wr.stamp_we = 1'b1;
                        wr.addr     = idx_reg;
                        wr.stamp    = now_reg;
                    end
                end
            end
            ST_FLUSH:
            begin
                // last retransmit of the scan carries the end mark
                if (pend_v_reg && out_free)
                begin
                    pend_v_next   = 1'b0;
                    out_v_next    = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            is_ack_reg <= 1'b0;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            valid_reg  <= '0;
            now_reg    <= '0;
            nseq_reg   <= '0;
            tss_reg    <= '0;
            intv_reg   <= INTV_W'(2);
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            is_ack_reg <= is_ack_next;
            cnt_reg    <= cnt_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            valid_reg  <= valid_next;
            now_reg    <= now_next;
            nseq_reg   <= nseq_next;
            tss_reg    <= tss_next;
            intv_reg   <= intv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ack_seq_reg <= ack_seq_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire
